/* hdl/tma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg: shared types and constants
// Operation codes, sequencer states and word layout of the matrix unit.
// ----------------------------------------------------------------------------
package tma_pkg;

   localparam int unsigned ELEM_W  = 32;
   localparam int unsigned LANES   = 4;
   localparam int unsigned COL_W   = ELEM_W * LANES;
   localparam int unsigned ACC_W   = 67;
   localparam int unsigned REQ_W   = 232;
   localparam int unsigned RSP_W   = 136;

   typedef enum logic [2:0] {
      OP_IDENTITY  = 3'd0,
      OP_LOAD_XLAT = 3'd1,
      OP_TRANSLATE = 3'd2,
      OP_LOAD_QUAT = 3'd3,
      OP_STORE_COL = 3'd4,
      OP_MULTIPLY  = 3'd5,
      OP_READ      = 3'd6,
      OP_SPARE     = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_OPND,
      ST_QMUL,
      ST_QWR,
      ST_MAC,
      ST_MWB,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

/* hdl/tma_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tma_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/transform_matrix_accumulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transform_matrix_accumulator_unit: 4x4 homogeneous transform matrix unit
// Holds a column-major current matrix and an operand matrix in RAM and
// applies one operation per request word, returning one matrix column.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------------------------
//   req     | in        | req_tvalid / req_tready | operation, column, elems, shift
//   rsp     | out       | rsp_tvalid / rsp_tready | column rows 0..3, saturated
//
// A request word is taken only while the sequencer is idle; the response
// register lets a new word enter while the previous response still waits.
// The multiply time is set by four multiply lanes reading one current-matrix
// column per cycle from the RAM, one result column per pass.
// Reset is synchronous and clears the RAM valid bits, so both matrices read
// as all zeros; there is no clearing pass. A stalled response holds the
// sequencer in its final state until the response register frees up.
//
module transform_matrix_accumulator_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // operation[2:0], column[4:3], elem_0..elem_3, shift_x, shift_y, shift_z
   // (32 bits each, from bit 5 up), zero pad [231:229]
   input  logic [tma_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_row_0..out_row_3 (32 bits each), saturated[128], zero pad [135:129]
   output logic [tma_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int unsigned EW = tma_pkg::ELEM_W;
   localparam int unsigned AW = tma_pkg::ACC_W;
   localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] ONE2 = AW'(1) << (2 * FRAC_BITS);

   // Shift right by the fraction width (floor) and clamp to 32 bits.
   // Bit 32 of the result flags a clamp.
   function automatic logic [EW:0] clamp(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v >>> FRAC_BITS;
      if (r > AW'(signed'(32'sh7fffffff))) begin
         return {1'b1, 32'h7fffffff};
      end else if (r < AW'(signed'(32'sh80000000))) begin
         return {1'b1, 32'h80000000};
      end
      return {1'b0, r[EW-1:0]};
   endfunction

   function automatic logic signed [AW-1:0] sx(input logic signed [63:0] p);
      return AW'(p);
   endfunction

   tma_pkg::state_type state_ff, state_in;
   tma_pkg::op_type    op_ff;
   logic [1:0]         col_ff;
   logic signed [EW-1:0] e_ff [4];
   logic signed [EW-1:0] s_ff [3];
   logic [2:0]         step_ff;
   logic [1:0]         pass_ff;
   logic               bank_ff;
   logic               sat_ff;
   logic [7:0]         cur_vld_ff;
   logic [3:0]         opd_vld_ff;
   logic               cur_rv_ff, opd_rv_ff;
   logic signed [63:0] prod_ff [4];
   logic signed [63:0] q_ff [9];
   logic signed [AW-1:0] acc_ff [4];
   logic               rsp_valid_ff;
   logic [EW-1:0]      rsp_row_ff [4];
   logic               rsp_sat_ff;

   logic               req_fire, rsp_free;
   logic [2:0]         cur_waddr, cur_raddr;
   logic               cur_we, opd_we;
   logic [tma_pkg::COL_W-1:0] cur_wdata, cur_rdata, opd_rdata;
   logic signed [EW-1:0] cur_rd [4];
   logic signed [EW-1:0] opd_rd [4];
   logic signed [EW-1:0] mul_a [4];
   logic signed [EW-1:0] mul_b [4];
   logic [1:0]         mk;
   logic [EW:0]        mac_res [4];
   logic [EW:0]        q_res [3];
   logic signed [AW-1:0] q_sum [3];
   logic [EW-1:0]      fill_col [4];

   assign req_tready = (state_ff == tma_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign mk         = 2'(step_ff - 3'd1);

   // Read data, masked by the valid bit of the entry that was read.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         cur_rd[r] = cur_rv_ff ? cur_rdata[r*EW +: EW] : '0;
         opd_rd[r] = opd_rv_ff ? opd_rdata[r*EW +: EW] : '0;
      end
   end

   assign cur_raddr = (state_ff == tma_pkg::ST_MAC) ? {bank_ff, step_ff[1:0]}
                                                    : {bank_ff, col_ff};

   // Multiply lane operands.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         mul_a[r] = cur_rd[r];
         if (op_ff == tma_pkg::OP_MULTIPLY) begin
            mul_b[r] = opd_rd[mk];
         end else if (mk == 2'd3) begin
            mul_b[r] = ONE;
         end else begin
            mul_b[r] = s_ff[mk];
         end
      end
      if (state_ff == tma_pkg::ST_QMUL) begin
         case (step_ff)
            3'd0: begin
               mul_a[0] = e_ff[0]; mul_b[0] = e_ff[0];
               mul_a[1] = e_ff[1]; mul_b[1] = e_ff[1];
               mul_a[2] = e_ff[2]; mul_b[2] = e_ff[2];
               mul_a[3] = e_ff[0]; mul_b[3] = e_ff[1];
            end
            3'd1: begin
               mul_a[0] = e_ff[0]; mul_b[0] = e_ff[2];
               mul_a[1] = e_ff[1]; mul_b[1] = e_ff[2];
               mul_a[2] = e_ff[3]; mul_b[2] = e_ff[0];
               mul_a[3] = e_ff[3]; mul_b[3] = e_ff[1];
            end
            default: begin
               for (int r = 0; r < 4; r++) begin
                  mul_a[r] = e_ff[3];
                  mul_b[r] = e_ff[2];
               end
            end
         endcase
      end
   end

   // Quaternion entries of column pass_ff; products xx yy zz xy xz yz wx wy wz.
   always_comb begin
      case (pass_ff)
         2'd0: begin
            q_sum[0] = ONE2 - (sx(q_ff[1]) <<< 1) - (sx(q_ff[2]) <<< 1);
            q_sum[1] = (sx(q_ff[3]) <<< 1) + (sx(q_ff[8]) <<< 1);
            q_sum[2] = (sx(q_ff[4]) <<< 1) - (sx(q_ff[7]) <<< 1);
         end
         2'd1: begin
            q_sum[0] = (sx(q_ff[3]) <<< 1) - (sx(q_ff[8]) <<< 1);
            q_sum[1] = ONE2 - (sx(q_ff[0]) <<< 1) - (sx(q_ff[2]) <<< 1);
            q_sum[2] = (sx(q_ff[5]) <<< 1) + (sx(q_ff[6]) <<< 1);
         end
         default: begin
            q_sum[0] = (sx(q_ff[4]) <<< 1) + (sx(q_ff[7]) <<< 1);
            q_sum[1] = (sx(q_ff[5]) <<< 1) - (sx(q_ff[6]) <<< 1);
            q_sum[2] = ONE2 - (sx(q_ff[0]) <<< 1) - (sx(q_ff[1]) <<< 1);
         end
      endcase
      for (int r = 0; r < 3; r++) begin
         q_res[r] = clamp(q_sum[r]);
      end
      for (int r = 0; r < 4; r++) begin
         mac_res[r] = clamp(acc_ff[r]);
      end
   end

   // Identity column, with the translation in column three for the loads.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         fill_col[r] = (2'(r) == pass_ff) ? ONE : '0;
      end
      if (pass_ff == 2'd3 && op_ff != tma_pkg::OP_IDENTITY) begin
         for (int r = 0; r < 3; r++) begin
            fill_col[r] = s_ff[r];
         end
      end
   end

   // RAM write port and sequencer.
   always_comb begin
      state_in  = state_ff;
      cur_we    = 1'b0;
      cur_waddr = {bank_ff, pass_ff};
      cur_wdata = {fill_col[3], fill_col[2], fill_col[1], fill_col[0]};
      opd_we    = 1'b0;
      unique case (state_ff)
         tma_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (tma_pkg::op_type'(req_tdata[2:0]))
                  tma_pkg::OP_IDENTITY, tma_pkg::OP_LOAD_XLAT:
                     state_in = tma_pkg::ST_FILL;
                  tma_pkg::OP_TRANSLATE, tma_pkg::OP_MULTIPLY:
                     state_in = tma_pkg::ST_MAC;
                  tma_pkg::OP_LOAD_QUAT: state_in = tma_pkg::ST_QMUL;
                  tma_pkg::OP_STORE_COL: state_in = tma_pkg::ST_OPND;
                  default:               state_in = tma_pkg::ST_READ;
               endcase
            end
         end
         tma_pkg::ST_FILL: begin
            cur_we = 1'b1;
            if (pass_ff == 2'd3) state_in = tma_pkg::ST_READ;
         end
         tma_pkg::ST_OPND: begin
            opd_we   = 1'b1;
            state_in = tma_pkg::ST_READ;
         end
         tma_pkg::ST_QMUL: begin
            if (step_ff == 3'd3) state_in = tma_pkg::ST_QWR;
         end
         tma_pkg::ST_QWR: begin
            cur_we = 1'b1;
            if (pass_ff != 2'd3) begin
               cur_wdata = {32'h0, q_res[2][EW-1:0], q_res[1][EW-1:0],
                            q_res[0][EW-1:0]};
            end else begin
               state_in = tma_pkg::ST_READ;
            end
         end
         tma_pkg::ST_MAC: begin
            if (step_ff == 3'd5) state_in = tma_pkg::ST_MWB;
         end
         tma_pkg::ST_MWB: begin
            cur_we    = 1'b1;
            cur_wdata = {mac_res[3][EW-1:0], mac_res[2][EW-1:0],
                         mac_res[1][EW-1:0], mac_res[0][EW-1:0]};
            if (op_ff == tma_pkg::OP_MULTIPLY) begin
               cur_waddr = {!bank_ff, pass_ff};
               state_in  = (pass_ff == 2'd3) ? tma_pkg::ST_READ : tma_pkg::ST_MAC;
            end else begin
               cur_waddr = {bank_ff, 2'd3};
               state_in  = tma_pkg::ST_READ;
            end
         end
         tma_pkg::ST_READ: begin
            state_in = tma_pkg::ST_RESP;
         end
         tma_pkg::ST_RESP: begin
            if (rsp_free) state_in = tma_pkg::ST_IDLE;
         end
         default: state_in = tma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         pass_ff      <= '0;
         bank_ff      <= 1'b0;
         cur_vld_ff   <= '0;
         opd_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cur_we) cur_vld_ff[cur_waddr] <= 1'b1;
         if (opd_we) opd_vld_ff[col_ff] <= 1'b1;
         if (state_ff == tma_pkg::ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            step_ff <= '0;
            pass_ff <= '0;
         end
         case (state_ff)
            tma_pkg::ST_FILL, tma_pkg::ST_QWR: pass_ff <= pass_ff + 2'd1;
            tma_pkg::ST_QMUL: step_ff <= (step_ff == 3'd3) ? 3'd0 : step_ff + 3'd1;
            tma_pkg::ST_MAC:  step_ff <= (step_ff == 3'd5) ? 3'd0 : step_ff + 3'd1;
            tma_pkg::ST_MWB: begin
               pass_ff <= pass_ff + 2'd1;
               if (op_ff == tma_pkg::OP_MULTIPLY && pass_ff == 2'd3) begin
                  bank_ff <= !bank_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cur_rv_ff <= cur_vld_ff[cur_raddr];
      opd_rv_ff <= opd_vld_ff[pass_ff];
      for (int r = 0; r < 4; r++) begin
         prod_ff[r] <= mul_a[r] * mul_b[r];
      end
      if (req_fire) begin
         op_ff  <= tma_pkg::op_type'(req_tdata[2:0]);
         col_ff <= req_tdata[4:3];
         for (int i = 0; i < 4; i++) e_ff[i] <= req_tdata[5 + i*EW +: EW];
         for (int i = 0; i < 3; i++) s_ff[i] <= req_tdata[133 + i*EW +: EW];
         sat_ff <= 1'b0;
      end
      if (state_ff == tma_pkg::ST_QMUL) begin
         case (step_ff)
            3'd1: for (int r = 0; r < 4; r++) q_ff[r] <= prod_ff[r];
            3'd2: for (int r = 0; r < 4; r++) q_ff[4 + r] <= prod_ff[r];
            3'd3: q_ff[8] <= prod_ff[0];
            default: ;
         endcase
      end
      if (state_ff == tma_pkg::ST_QWR && pass_ff != 2'd3) begin
         sat_ff <= sat_ff | q_res[0][EW] | q_res[1][EW] | q_res[2][EW];
      end
      if (state_ff == tma_pkg::ST_MAC && step_ff >= 3'd2) begin
         for (int r = 0; r < 4; r++) begin
            acc_ff[r] <= (step_ff == 3'd2) ? sx(prod_ff[r]) : acc_ff[r] + sx(prod_ff[r]);
         end
      end
      if (state_ff == tma_pkg::ST_MWB) begin
         sat_ff <= sat_ff | mac_res[0][EW] | mac_res[1][EW] | mac_res[2][EW]
                          | mac_res[3][EW];
      end
      if (state_ff == tma_pkg::ST_RESP && rsp_free) begin
         for (int r = 0; r < 4; r++) rsp_row_ff[r] <= cur_rd[r];
         rsp_sat_ff <= sat_ff;
      end
   end

   tma_ram #(.WIDTH(tma_pkg::COL_W), .DEPTH(8)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (cur_raddr),
      .rd_data (cur_rdata)
   );

   tma_ram #(.WIDTH(tma_pkg::COL_W), .DEPTH(4)) u_opd_ram (
      .clock   (clock),
      .wr_en   (opd_we),
      .wr_addr (col_ff),
      .wr_data ({e_ff[3], e_ff[2], e_ff[1], e_ff[0]}),
      .rd_addr (pass_ff),
      .rd_data (opd_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'h0, rsp_sat_ff, rsp_row_ff[3], rsp_row_ff[2],
                        rsp_row_ff[1], rsp_row_ff[0]};

endmodule

/* hdl/tma_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_checker: port-level checks for the matrix unit
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module tma_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [tma_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [tma_pkg::RSP_W-1:0] rsp_tdata
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Only one word is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A response cannot appear in the cycle after a word is taken.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response too early");

   // A read of the matrix never reports a clamp.
   a_read_no_sat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[2:0] == tma_pkg::OP_READ)
      |=> ##2 !$rose(rsp_tvalid) || !rsp_tdata[128])
      else $error("read reported a clamp");

endmodule

bind transform_matrix_accumulator_unit tma_checker u_tma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
